[sv/srfo_pkg.sv]
// Shared types for the section address-to-file-offset unit.
// No dependencies; used by srfo_match and section_rva_to_file_offset_unit.
package srfo_pkg;

	typedef enum logic [0:0] {
		FUNC_LOAD      = 1'b0,
		FUNC_TRANSLATE = 1'b1
	} func_t;

	// One section table entry as held in the table memory.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic [31:0] file_pos;
	} sec_entry_t;

	// Result of checking one address against one entry.
	typedef struct packed {
		logic        hit;
		logic        above;
		logic [31:0] diff;
	} sec_match_t;

endpackage

[sv/srfo_match.sv]
// Range check of one address against one section entry.
// Depends on srfo_pkg.
module srfo_match (
	input  logic [31:0]         addr,
	input  srfo_pkg::sec_entry_t entry,
	output srfo_pkg::sec_match_t match
);
	import srfo_pkg::*;

	logic [31:0] sec_end;

	// end wraps mod 2^32; a wrapped range is empty under the unsigned compare
	assign sec_end     = entry.start + entry.size;
	assign match.hit   = (addr >= entry.start) && (addr < sec_end);
	assign match.above = addr > entry.start;
	assign match.diff  = addr - entry.start;

endmodule

[sv/section_rva_to_file_offset_unit.sv]
// Top level of the section address-to-file-offset unit: section table memory,
// scan sequencer and result register. Depends on srfo_pkg and srfo_match.
//
// A load request (func = 0) writes one table entry in the cycle it is taken and
// keeps busy low; it gives no result. A translate request (func = 1) reads the
// table through its single read port, one entry per cycle, and scans n =
// min(section_count, MAX_SECTIONS) entries; with n = 0 it goes straight
// to the finishing state, and a hit on entry k ends the scan early. busy
// stays high through the scan and the finishing state, until the result is
// presented. The receiver cannot stall: done is high for exactly one cycle
// with file_offset and error valid, and a new request may be taken in that
// same cycle. The table has no reset: translate only over entries that were
// loaded.
module section_rva_to_file_offset_unit #(
	parameter int MAX_SECTIONS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [0:0]  func,
	input  logic [4:0]  entry_index,
	input  logic [31:0] section_start,
	input  logic [31:0] section_raw_size,
	input  logic [31:0] section_file_pos,
	input  logic [31:0] address,
	input  logic        section_count_we,
	input  logic [5:0]  section_count_wdata,
	output logic        done,
	output logic [31:0] file_offset,
	output logic        error
);
	import srfo_pkg::*;

	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t        state_q;
	logic [5:0]    count_q;
	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] cmp_idx_s1;
	logic          valid_s1;
	logic [31:0]   addr_q;
	logic          below_q;
	logic          hit_q;
	logic [31:0]   diff_q;
	logic [31:0]   fpos_q;
	logic          accept;
	logic          load_wr;
	logic          rd_en;
	logic          last_s1;

	sec_entry_t    mem [MAX_SECTIONS];
	sec_entry_t    rd_data_s1;
	sec_match_t    match;

	assign accept  = start && !busy;
	assign load_wr = accept && (func_t'(func) == FUNC_LOAD)
		&& ({27'b0, entry_index} < 32'(MAX_SECTIONS));
	assign busy    = (state_q != ST_IDLE);
	assign rd_en   = (state_q == ST_SCAN) && (iss_q < lim_q);
	assign last_s1 = (CNT_W'(cmp_idx_s1 + 1'b1) == lim_q);

	always_comb begin
		if ({26'b0, count_q} > 32'(MAX_SECTIONS)) begin
			lim = CNT_W'(MAX_SECTIONS);
		end else begin
			lim = CNT_W'(count_q);
		end
	end

	// Table memory: one write port (loads, idle only), one registered read port.
	// Loads cannot be taken during a scan, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem[IDX_W'(entry_index)] <= '{start: section_start, size: section_raw_size,
				file_pos: section_file_pos};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[iss_q[IDX_W-1:0]];
		end
	end

	srfo_match u_match (
		.addr  (addr_q),
		.entry (rd_data_s1),
		.match (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (section_count_we) begin
			count_q <= section_count_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_s1   <= 1'b0;
			iss_q      <= '0;
			cmp_idx_s1 <= '0;
			lim_q      <= '0;
			below_q    <= 1'b0;
			hit_q      <= 1'b0;
			done       <= 1'b0;
			error      <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (func_t'(func) == FUNC_TRANSLATE)) begin
						lim_q    <= lim;
						iss_q    <= '0;
						valid_s1 <= 1'b0;
						below_q  <= 1'b0;
						hit_q    <= 1'b0;
						state_q  <= (lim == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					valid_s1 <= rd_en;
					if (rd_en) begin
						iss_q      <= CNT_W'(iss_q + 1'b1);
						cmp_idx_s1 <= iss_q;
					end
					if (valid_s1) begin
						if (match.hit) begin
							hit_q    <= 1'b1;
							valid_s1 <= 1'b0;
							state_q  <= ST_FIN;
						end else begin
							below_q <= below_q | match.above;
							if (last_s1) begin
								valid_s1 <= 1'b0;
								state_q  <= ST_FIN;
							end
						end
					end
				end
				ST_FIN: begin
					done    <= 1'b1;
					error   <= !hit_q && below_q;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			addr_q <= address;
		end
		if (state_q == ST_SCAN && valid_s1 && match.hit) begin
			diff_q <= match.diff;
			fpos_q <= rd_data_s1.file_pos;
		end
		if (state_q == ST_FIN) begin
			if (hit_q) begin
				file_offset <= diff_q + fpos_q;
			end else if (below_q) begin
				file_offset <= '0;
			end else begin
				file_offset <= addr_q;
			end
		end
	end

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("done without a finishing cycle");

	a_error_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done && error |-> file_offset == '0)
		else $error("error result with nonzero offset");

	a_translate_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func_t'(func) == FUNC_TRANSLATE) |=> busy)
		else $error("translate request did not raise busy");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> iss_q <= lim_q)
		else $error("read issue ran past the scan limit");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !load_wr)
		else $error("table write during a scan");

endmodule
